FILE: hdl/pdt_pkg.sv
// Shared types and constants for the polyline distance trim block.
package pdt_pkg;

  // Request action codes
  localparam logic [2:0] ACT_WRITE = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_SETC  = 3'd2;
  localparam logic [2:0] ACT_SETB  = 3'd3;
  localparam logic [2:0] ACT_TRIM  = 3'd4;

  // Shared arithmetic unit operations
  localparam logic OP_SQRT = 1'b0;
  localparam logic OP_DIV  = 1'b1;

  // Operand widths of the shared unit
  localparam int OPA_W = 34;  // radicand / dividend magnitude
  localparam int OPB_W = 17;  // divisor (segment length)
  localparam int RES_W = 17;  // root / quotient

  typedef struct packed {
    logic start;
    logic op;
  } pdt_arith_ctl_t;

endpackage

FILE: hdl/pdt_ram.sv
// Generic single write port, single read port RAM with registered read data.
module pdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

FILE: hdl/pdt_arith.sv
// Iterative square root and unsigned divide sharing one compare/subtract path.
module pdt_arith (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pdt_pkg::pdt_arith_ctl_t       ctl,
  input  logic [pdt_pkg::OPA_W-1:0]     opa,
  input  logic [pdt_pkg::OPB_W-1:0]     opb,
  output logic                          done_r,
  output logic [pdt_pkg::RES_W-1:0]     result
);

  localparam int W = pdt_pkg::OPA_W;
  localparam logic [5:0] SQRT_STEPS = 6'd17;
  localparam logic [5:0] DIV_STEPS  = 6'd34;

  logic         busy_r;
  logic         op_r;
  logic [5:0]   cnt_r;
  logic [W-1:0] work_r;  // remaining radicand, or dividend shifting out
  logic [W-1:0] res_r;   // root, or quotient shifting in
  logic [W-1:0] aux_r;   // trial bit, or partial remainder
  logic [pdt_pkg::OPB_W-1:0] dvs_r;

  logic [W+2:0] cmp_a, cmp_b, diff;
  logic         ge;

  // Shared trial subtraction
  always_comb begin
    if (op_r == pdt_pkg::OP_SQRT) begin
      cmp_a = {3'b000, work_r};
      cmp_b = {3'b000, res_r} + {3'b000, aux_r};
    end else begin
      cmp_a = {{(W+2-pdt_pkg::OPB_W){1'b0}}, aux_r[pdt_pkg::OPB_W-1:0], work_r[W-1]};
      cmp_b = {{(W+3-pdt_pkg::OPB_W){1'b0}}, dvs_r};
    end
    diff = cmp_a - cmp_b;
    ge   = ~diff[W+2];
  end

  assign result = res_r[pdt_pkg::RES_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        op_r   <= ctl.op;
        work_r <= opa;
        res_r  <= '0;
        dvs_r  <= opb;
        cnt_r  <= (ctl.op == pdt_pkg::OP_SQRT) ? SQRT_STEPS : DIV_STEPS;
        aux_r  <= (ctl.op == pdt_pkg::OP_SQRT) ? (W'(1) << (W - 2)) : '0;
      end else if (busy_r) begin
        if (op_r == pdt_pkg::OP_SQRT) begin
          if (ge) begin
            work_r <= diff[W-1:0];
            res_r  <= (res_r >> 1) + aux_r;
          end else begin
            res_r  <= res_r >> 1;
          end
          aux_r <= aux_r >> 2;
        end else begin
          work_r <= work_r << 1;
          res_r  <= {res_r[W-2:0], ge};
          aux_r  <= ge ? diff[W-1:0] : cmp_a[W-1:0];
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/polyline_distance_trim.sv
// Point path store with distance trim, compaction and bound growth.
// Write/set actions finish in S_EXEC; a read adds S_RDW for the registered RAM data.
// Trim: a square root (17 steps) per walked segment, two 34-step divides
// for the reached point, then a copy of each kept point.
// One request at a time; ready only while idle. Trim pace is set by the shared
// square root / divide unit. Sync reset clears count, marks and bounds.
module polyline_distance_trim #(
  parameter int MAX_POINTS = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic [7:0]         in_index_a,
  input  logic [6:0]         in_index_b,
  input  logic signed [9:0]  in_mark_first_in,
  input  logic signed [9:0]  in_mark_last_in,
  input  logic signed [15:0] in_value_x,
  input  logic signed [15:0] in_value_y,
  input  logic signed [15:0] in_corner_x,
  input  logic signed [15:0] in_corner_y,
  input  logic [23:0]        in_distance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_status,
  output logic signed [15:0] out_point_x,
  output logic signed [15:0] out_point_y,
  output logic [7:0]         out_point_count,
  output logic signed [9:0]  out_mark_first,
  output logic signed [9:0]  out_mark_last,
  output logic signed [15:0] out_min_x,
  output logic signed [15:0] out_min_y,
  output logic signed [15:0] out_max_x,
  output logic signed [15:0] out_max_y
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam logic [7:0] CNT_CAP = (MAX_POINTS > 255) ? 8'd255 : 8'(MAX_POINTS);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_EXEC  = 5'd1;
  localparam logic [4:0] S_RDW   = 5'd2;
  localparam logic [4:0] S_RESP  = 5'd3;
  localparam logic [4:0] W_RD    = 5'd4;
  localparam logic [4:0] W_DAT   = 5'd5;
  localparam logic [4:0] W_SQX   = 5'd6;
  localparam logic [4:0] W_SQY   = 5'd7;
  localparam logic [4:0] W_SUM   = 5'd8;
  localparam logic [4:0] W_SQGO  = 5'd9;
  localparam logic [4:0] W_SQW   = 5'd10;
  localparam logic [4:0] W_CHK   = 5'd11;
  localparam logic [4:0] W_MUL   = 5'd12;
  localparam logic [4:0] W_DVGO  = 5'd13;
  localparam logic [4:0] W_DVW   = 5'd14;
  localparam logic [4:0] W_WR    = 5'd15;
  localparam logic [4:0] T_MARK  = 5'd16;
  localparam logic [4:0] C_RD    = 5'd17;
  localparam logic [4:0] C_WR    = 5'd18;

  logic [4:0] state_r;

  // Latched request
  logic [2:0]         act_r;
  logic [7:0]         ia_r;
  logic [6:0]         ib_r;
  logic signed [9:0]  mfi_r, mli_r;
  logic signed [15:0] vx_r, vy_r, cx_r, cy_r;
  logic [23:0]        dist_r;

  // Architectural state
  logic [7:0]         cnt_r;
  logic signed [9:0]  mf_r, ml_r;
  logic signed [15:0] minx_r, miny_r, maxx_r, maxy_r;

  // Result payload
  logic               status_r;
  logic signed [15:0] px_out_r, py_out_r;

  // Walk datapath
  logic               dir_r, sel_y_r, neg_r;
  logic [7:0]         idx_r, start_r, end_r, k_r;
  logic signed [15:0] ax_r, ay_r, px_r, py_r, qx_r, qy_r;
  logic signed [16:0] dx_r, dy_r;
  logic [33:0]        sq_r;
  logic [16:0]        seg_r, rem_r;
  logic [24:0]        acc_r;
  logic signed [35:0] prod_r;

  // RAM and shared unit wiring
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;
  pdt_pkg::pdt_arith_ctl_t arith_ctl;
  logic [33:0]        arith_opa;
  logic               arith_done;
  logic [16:0]        arith_res;

  logic signed [17:0] mul_a, mul_b;
  logic [35:0]        prod_mag;
  logic [24:0]        acc_sum;
  logic signed [15:0] rd_x, rd_y;
  logic signed [10:0] mf_sub, ml_sub, k_s;
  logic               in_marks;
  logic signed [15:0] quot_s;

  pdt_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  pdt_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (arith_ctl),
    .opa    (arith_opa),
    .opb    (seg_r),
    .done_r (arith_done),
    .result (arith_res)
  );

  assign rd_x = ram_rdata[15:0];
  assign rd_y = ram_rdata[31:16];

  // Port outputs
  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_RESP);
  assign out_status      = status_r;
  assign out_point_x     = px_out_r;
  assign out_point_y     = py_out_r;
  assign out_point_count = cnt_r;
  assign out_mark_first  = mf_r;
  assign out_mark_last   = ml_r;
  assign out_min_x       = minx_r;
  assign out_min_y       = miny_r;
  assign out_max_x       = maxx_r;
  assign out_max_y       = maxy_r;

  // Memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(idx_r);
    ram_wdata = {vy_r, vx_r};
    ram_raddr = AW'(idx_r);
    unique case (state_r)
      S_EXEC: begin
        ram_raddr = AW'(ia_r);
        ram_waddr = AW'(ia_r);
        ram_we    = (act_r == pdt_pkg::ACT_WRITE) && (ia_r < cnt_r);
      end
      W_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {ay_r + qy_r, ax_r + qx_r};
      end
      C_RD: ram_raddr = AW'(start_r);
      C_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(k_r);
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  // Multiplier operands and shared unit control
  always_comb begin
    mul_a = {dx_r[16], dx_r};
    mul_b = {dx_r[16], dx_r};
    unique case (state_r)
      W_SQY: begin
        mul_a = {dy_r[16], dy_r};
        mul_b = {dy_r[16], dy_r};
      end
      W_MUL: begin
        mul_a = sel_y_r ? {dy_r[16], dy_r} : {dx_r[16], dx_r};
        mul_b = {1'b0, rem_r};
      end
      default: ;
    endcase
    prod_mag        = prod_r[35] ? 36'(-prod_r) : 36'(prod_r);
    arith_ctl.start = (state_r == W_SQGO) || (state_r == W_DVGO);
    arith_ctl.op    = (state_r == W_SQGO) ? pdt_pkg::OP_SQRT : pdt_pkg::OP_DIV;
    arith_opa       = (state_r == W_SQGO) ? sq_r : prod_mag[33:0];
    acc_sum         = acc_r + {8'd0, seg_r};
    quot_s          = neg_r ? -$signed(arith_res[15:0]) : $signed(arith_res[15:0]);
    mf_sub          = {mf_r[9], mf_r} - $signed({3'b000, start_r});
    ml_sub          = {ml_r[9], ml_r} - $signed({3'b000, start_r});
    k_s             = $signed({3'b000, k_r});
    // signed compare against the rebased marks
    in_marks        = (k_s >= $signed({mf_r[9], mf_r})) &&
                      (k_s <= $signed({ml_r[9], ml_r}));
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      mf_r    <= '0;
      ml_r    <= '0;
      minx_r  <= '0;
      miny_r  <= '0;
      maxx_r  <= '0;
      maxy_r  <= '0;
    end else begin
      prod_r <= mul_a * mul_b;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r   <= in_action;
            ia_r    <= in_index_a;
            ib_r    <= in_index_b;
            mfi_r   <= in_mark_first_in;
            mli_r   <= in_mark_last_in;
            vx_r    <= in_value_x;
            vy_r    <= in_value_y;
            cx_r    <= in_corner_x;
            cy_r    <= in_corner_y;
            dist_r  <= in_distance;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          status_r <= 1'b0;
          px_out_r <= '0;
          py_out_r <= '0;
          state_r  <= S_RESP;
          unique case (act_r)
            pdt_pkg::ACT_WRITE: status_r <= (ia_r >= cnt_r);
            pdt_pkg::ACT_READ: begin
              if (ia_r >= cnt_r) status_r <= 1'b1;
              else state_r <= S_RDW;
            end
            pdt_pkg::ACT_SETC: begin
              cnt_r <= (ia_r > CNT_CAP) ? CNT_CAP : ia_r;
              mf_r  <= mfi_r;
              ml_r  <= mli_r;
            end
            pdt_pkg::ACT_SETB: begin
              minx_r <= vx_r;
              miny_r <= vy_r;
              maxx_r <= cx_r;
              maxy_r <= cy_r;
            end
            pdt_pkg::ACT_TRIM: begin
              if (ia_r >= cnt_r || {1'b0, ib_r} >= cnt_r) begin
                status_r <= 1'b1;
              end else begin
                idx_r   <= ia_r;
                dir_r   <= 1'b0;
                ax_r    <= vx_r;
                ay_r    <= vy_r;
                acc_r   <= '0;
                state_r <= W_RD;
              end
            end
            default: ;
          endcase
        end
        S_RDW: begin
          px_out_r <= rd_x;
          py_out_r <= rd_y;
          state_r  <= S_RESP;
        end
        S_RESP: if (out_ready) state_r <= S_IDLE;
        // Segment from anchor to the next point
        W_RD: state_r <= W_DAT;
        W_DAT: begin
          px_r    <= rd_x;
          py_r    <= rd_y;
          dx_r    <= {rd_x[15], rd_x} - {ax_r[15], ax_r};
          dy_r    <= {rd_y[15], rd_y} - {ay_r[15], ay_r};
          state_r <= W_SQX;
        end
        W_SQX: state_r <= W_SQY;
        W_SQY: begin
          sq_r    <= prod_r[33:0];
          state_r <= W_SUM;
        end
        W_SUM: begin
          sq_r    <= sq_r + prod_r[33:0];
          state_r <= W_SQGO;
        end
        W_SQGO: state_r <= W_SQW;
        W_SQW: begin
          if (arith_done) begin
            seg_r   <= arith_res;
            state_r <= W_CHK;
          end
        end
        // Reached the distance, or step on; a walk that runs out turns or ends
        W_CHK: begin
          if (acc_sum >= {1'b0, dist_r}) begin
            rem_r   <= 17'({1'b0, dist_r} - acc_r);
            sel_y_r <= 1'b0;
            qx_r    <= '0;
            qy_r    <= '0;
            state_r <= (seg_r == '0) ? W_WR : W_MUL;
          end else if (dir_r == 1'b0 && idx_r == '0) begin
            // backward walk ran out: keep from index 0
            start_r <= idx_r;
            dir_r   <= 1'b1;
            idx_r   <= {1'b0, ib_r};
            ax_r    <= vx_r;
            ay_r    <= vy_r;
            acc_r   <= '0;
            state_r <= W_RD;
          end else begin
            ax_r  <= px_r;
            ay_r  <= py_r;
            acc_r <= acc_sum;
            if (dir_r == 1'b0) begin
              idx_r   <= idx_r - 8'd1;
              state_r <= W_RD;
            end else begin
              if ({1'b0, idx_r} + 9'd1 >= {1'b0, cnt_r}) begin
                end_r   <= idx_r;
                state_r <= T_MARK;
              end else begin
                idx_r   <= idx_r + 8'd1;
                state_r <= W_RD;
              end
            end
          end
        end
        // Interpolate: delta * remainder / length
        W_MUL: state_r <= W_DVGO;
        W_DVGO: begin
          neg_r   <= prod_r[35];
          state_r <= W_DVW;
        end
        W_DVW: begin
          if (arith_done) begin
            if (!sel_y_r) begin
              qx_r    <= quot_s;
              sel_y_r <= 1'b1;
              state_r <= W_MUL;
            end else begin
              qy_r    <= quot_s;
              state_r <= W_WR;
            end
          end
        end
        W_WR: begin
          if (dir_r == 1'b0) begin
            start_r <= idx_r;
            dir_r   <= 1'b1;
            idx_r   <= {1'b0, ib_r};
            ax_r    <= vx_r;
            ay_r    <= vy_r;
            acc_r   <= '0;
            state_r <= W_RD;
          end else begin
            end_r   <= idx_r;
            state_r <= T_MARK;
          end
        end
        // Rebase marks, then compact the kept range and grow bounds over marked points
        T_MARK: begin
          mf_r <= (mf_sub < -11'sd512) ? -10'sd512 : mf_sub[9:0];
          ml_r <= (ml_sub < -11'sd512) ? -10'sd512 : ml_sub[9:0];
          k_r  <= '0;
          if (start_r > end_r) begin
            cnt_r   <= '0;
            state_r <= S_RESP;
          end else begin
            state_r <= C_RD;
          end
        end
        C_RD: state_r <= C_WR;
        C_WR: begin
          if (in_marks) begin
            if (rd_x < minx_r) minx_r <= rd_x;
            if (rd_x > maxx_r) maxx_r <= rd_x;
            if (rd_y < miny_r) miny_r <= rd_y;
            if (rd_y > maxy_r) maxy_r <= rd_y;
          end
          if (start_r == end_r) begin
            cnt_r   <= k_r + 8'd1;
            state_r <= S_RESP;
          end else begin
            k_r     <= k_r + 8'd1;
            start_r <= start_r + 8'd1;
            state_r <= C_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
